// ===== rtl/tit_pkg.sv =====
// Shared constants and the divide-by-fifteen helper for the tetrahedron inertia tensor block.
package tit_pkg;

    // Result field width and the packed result bus width (six fields, padded to bytes).
    localparam int OUT_BITS     = 49;
    localparam int M_TDATA_BITS = ((6 * OUT_BITS + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_TDATA_BITS - 6 * OUT_BITS;

    // Divisors of the diagonal moments and of the products of inertia.
    // Both are fifteen times a power of two, so a quotient is a shift followed by
    // a divide by fifteen.
    localparam int DIV_MOM  = 60;
    localparam int DIV_PROD = 120;
    localparam int SH_MOM   = 2;
    localparam int SH_PROD  = 3;

    // Any remainder is below 120, so it fits in seven bits.
    localparam int DR_BITS = 7;

    // floor(n / 15) = (n * RECIP15_MUL) >> RECIP15_SHIFT, exact for n below 2^32.
    localparam logic [31:0] RECIP15_MUL   = 32'd2290649225;
    localparam int          RECIP15_SHIFT = 35;

    // Saturation bounds of the result fields.
    localparam logic [63:0] MOM_MAX      = 64'h0001_FFFF_FFFF_FFFF;
    localparam logic [63:0] PROD_MAX     = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] PROD_MIN_MAG = 64'h0001_0000_0000_0000;

    function automatic logic [31:0] div15(input logic [31:0] n);
        logic [63:0] prod;
        prod = 64'(n) * 64'(RECIP15_MUL);
        return 32'(prod >> RECIP15_SHIFT);
    endfunction

endpackage

// ===== rtl/tetrahedron_inertia_tensor_top.sv =====
// Top level of the tetrahedron inertia tensor pipeline.
//
// Each request on the slave channel carries the four vertices of a tetrahedron as
// twelve signed coordinates; each request produces exactly one result on the master
// channel: the three diagonal moments and the three products of inertia of the solid
// about the origin, at unit density.
// The datapath is a ten-stage register pipeline. A request passes through every stage
// in order before its result is presented, and while m_tready is high a new request
// is taken every cycle, so the sustained rate is one tetrahedron per clock. The depth
// is set by the determinant (two chained multiplies) followed by the divide by 60 or
// 120, which is carried out as reciprocal multiplies and a remainder correction.
// Every stage has its own valid bit and loads whenever it is empty or its successor
// moves, so bubbles close up. When the receiver holds m_tready low, the result stays
// in the output register and the stages behind it keep filling; s_tready falls only
// once every stage holds a request.
// The reset is synchronous and active low. It clears all valid bits, so no result is
// presented after reset; data registers are not reset.
module tetrahedron_inertia_tensor_top #(
    parameter int  COORD_BITS   = 10,
    localparam int S_TDATA_BITS = ((12 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // From the lowest bit: vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y,
    // vertex1_z, vertex2_x, vertex2_y, vertex2_z, vertex3_x, vertex3_y, vertex3_z.
    input  logic [S_TDATA_BITS-1:0]            s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // From the lowest bit: moment_xx, moment_yy, moment_zz, product_xy, product_xz,
    // product_yz, then zero padding.
    output logic [tit_pkg::M_TDATA_BITS-1:0]   m_tdata
);
    import tit_pkg::*;

    localparam int CB          = COORD_BITS;
    localparam int DF_BITS     = CB + 1;
    localparam int SUM_BITS    = CB + 2;
    localparam int SQS_BITS    = 2 * CB + 3;
    localparam int SX_BITS     = 2 * CB + 4;
    localparam int QD_BITS     = 2 * CB + 1;
    localparam int QX_BITS     = 2 * CB + 2;
    localparam int CP_BITS     = 2 * CB + 2;
    localparam int CR_BITS     = 2 * CB + 3;
    localparam int SYM_BITS    = 2 * CB + 2;
    localparam int SM_BITS     = 2 * CB + 3;
    localparam int SS_BITS     = 2 * CB + 4;
    localparam int T_BITS      = 3 * CB + 4;
    localparam int D_BITS      = 3 * CB + 3;
    localparam int DQ_BITS     = 3 * CB - 2;
    localparam int NSTAGE      = 10;
    localparam int PAIR_A [3]  = '{0, 0, 1};
    localparam int PAIR_B [3]  = '{1, 2, 2};

    // Pipeline control: a stage loads when it is empty or its successor moves.
    logic [NSTAGE:1]   valid_reg;
    logic [NSTAGE+1:1] ready;
    logic [NSTAGE:1]   valid_in;

    always_comb begin
        ready[NSTAGE+1] = m_tready;
        for (int k = NSTAGE; k >= 1; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_in[1] = s_tvalid;
        for (int k = 2; k <= NSTAGE; k++) begin
            valid_in[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 1; k <= NSTAGE; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    assign s_tready = ready[1];
    assign m_tvalid = valid_reg[NSTAGE];

    // Stage 1: unpack the coordinates (axis, vertex), form the edge vectors from
    // vertex 0 (axis, edge) and the coordinate sum along each axis.
    logic signed [CB-1:0]       in_c [3][4];
    logic signed [CB-1:0]       r1_c_reg [3][4];
    logic signed [DF_BITS-1:0]  r1_d_reg [3][3], r1_d_next [3][3];
    logic signed [SUM_BITS-1:0] r1_s_reg [3], r1_s_next [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int v = 0; v < 4; v++) begin
                in_c[a][v] = s_tdata[(3 * v + a) * CB +: CB];
            end
            for (int e = 0; e < 3; e++) begin
                r1_d_next[a][e] = DF_BITS'(in_c[a][e+1]) - DF_BITS'(in_c[a][0]);
            end
            r1_s_next[a] = SUM_BITS'(in_c[a][0]) + SUM_BITS'(in_c[a][1])
                         + SUM_BITS'(in_c[a][2]) + SUM_BITS'(in_c[a][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[1]) begin
            r1_c_reg <= in_c;
            r1_d_reg <= r1_d_next;
            r1_s_reg <= r1_s_next;
        end
    end

    // Stage 2: the pairwise products. A symmetric sum over i <= j equals half of the
    // squared axis sum plus the sum of squares; the mixed sum with doubled diagonal is
    // the product of the axis sums plus the sum of per-vertex products.
    logic signed [CP_BITS-1:0]  r2_m_reg [6], r2_m_next [6];
    logic signed [DF_BITS-1:0]  r2_e_reg [3];
    logic [SQS_BITS-1:0]        r2_ss_reg [3], r2_ss_next [3];
    logic [QD_BITS-1:0]         r2_q_reg [3], r2_q_next [3];
    logic signed [SX_BITS-1:0]  r2_sp_reg [3], r2_sp_next [3];
    logic signed [QX_BITS-1:0]  r2_qp_reg [3], r2_qp_next [3];

    always_comb begin
        // Cofactor products of the edge matrix, edges a, b, c = 0, 1, 2.
        r2_m_next[0] = CP_BITS'(r1_d_reg[1][1]) * CP_BITS'(r1_d_reg[2][2]);
        r2_m_next[1] = CP_BITS'(r1_d_reg[2][1]) * CP_BITS'(r1_d_reg[1][2]);
        r2_m_next[2] = CP_BITS'(r1_d_reg[1][2]) * CP_BITS'(r1_d_reg[2][0]);
        r2_m_next[3] = CP_BITS'(r1_d_reg[1][0]) * CP_BITS'(r1_d_reg[2][2]);
        r2_m_next[4] = CP_BITS'(r1_d_reg[1][0]) * CP_BITS'(r1_d_reg[2][1]);
        r2_m_next[5] = CP_BITS'(r1_d_reg[1][1]) * CP_BITS'(r1_d_reg[2][0]);
        for (int a = 0; a < 3; a++) begin
            r2_ss_next[a] = SQS_BITS'(SX_BITS'(r1_s_reg[a]) * SX_BITS'(r1_s_reg[a]));
            r2_q_next[a]  = '0;
            for (int v = 0; v < 4; v++) begin
                r2_q_next[a] = r2_q_next[a]
                             + QD_BITS'(QX_BITS'(r1_c_reg[a][v]) * QX_BITS'(r1_c_reg[a][v]));
            end
        end
        for (int p = 0; p < 3; p++) begin
            r2_sp_next[p] = SX_BITS'(r1_s_reg[PAIR_A[p]]) * SX_BITS'(r1_s_reg[PAIR_B[p]]);
            r2_qp_next[p] = '0;
            for (int v = 0; v < 4; v++) begin
                r2_qp_next[p] = r2_qp_next[p] + QX_BITS'(r1_c_reg[PAIR_A[p]][v])
                                              * QX_BITS'(r1_c_reg[PAIR_B[p]][v]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[2]) begin
            r2_m_reg  <= r2_m_next;
            r2_ss_reg <= r2_ss_next;
            r2_q_reg  <= r2_q_next;
            r2_sp_reg <= r2_sp_next;
            r2_qp_reg <= r2_qp_next;
            for (int e = 0; e < 3; e++) begin
                r2_e_reg[e] <= r1_d_reg[0][e];
            end
        end
    end

    // Stage 3: cofactors of the x column and the six coordinate sums. Entries 0 to 2
    // feed the diagonal moments, entries 3 to 5 the xy, xz and yz products.
    logic signed [CR_BITS-1:0]  r3_cr_reg [3], r3_cr_next [3];
    logic signed [DF_BITS-1:0]  r3_e_reg [3];
    logic signed [SS_BITS-1:0]  r3_s_reg [6], r3_s_next [6];
    logic [SYM_BITS-1:0]        sym [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r3_cr_next[k] = CR_BITS'(r2_m_reg[2*k]) - CR_BITS'(r2_m_reg[2*k+1]);
        end
        for (int a = 0; a < 3; a++) begin
            sym[a] = SYM_BITS'((SX_BITS'(r2_ss_reg[a]) + SX_BITS'(r2_q_reg[a])) >> 1);
        end
        r3_s_next[0] = SS_BITS'(SM_BITS'(sym[1]) + SM_BITS'(sym[2]));
        r3_s_next[1] = SS_BITS'(SM_BITS'(sym[0]) + SM_BITS'(sym[2]));
        r3_s_next[2] = SS_BITS'(SM_BITS'(sym[0]) + SM_BITS'(sym[1]));
        for (int p = 0; p < 3; p++) begin
            r3_s_next[3+p] = SS_BITS'(r2_sp_reg[p]) + SS_BITS'(r2_qp_reg[p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[3]) begin
            r3_cr_reg <= r3_cr_next;
            r3_e_reg  <= r2_e_reg;
            r3_s_reg  <= r3_s_next;
        end
    end

    // Stage 4: the three terms of the determinant expansion along the x column.
    logic signed [T_BITS-1:0]  r4_t_reg [3], r4_t_next [3];
    logic signed [SS_BITS-1:0] r4_s_reg [6];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            r4_t_next[k] = T_BITS'(r3_e_reg[k]) * T_BITS'(r3_cr_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ready[4]) begin
            r4_t_reg <= r4_t_next;
            r4_s_reg <= r3_s_reg;
        end
    end

    // Stage 5: absolute determinant.
    logic signed [T_BITS-1:0]  tsum;
    logic [D_BITS-1:0]         r5_d_reg, r5_d_next;
    logic signed [SS_BITS-1:0] r5_s_reg [6];

    always_comb begin
        tsum      = r4_t_reg[0] + r4_t_reg[1] + r4_t_reg[2];
        r5_d_next = D_BITS'((tsum < 0) ? -tsum : tsum);
    end

    always_ff @(posedge aclk) begin
        if (ready[5]) begin
            r5_d_reg <= r5_d_next;
            r5_s_reg <= r4_s_reg;
        end
    end

    // Stages 6 and 7: split the determinant by 60 and by 120 into quotient and
    // remainder, shared by the three lanes of each kind.
    logic [D_BITS-1:0]  r6_d_reg;
    logic [DQ_BITS-1:0] r6_dqm_reg, r6_dqp_reg;
    logic [DQ_BITS-1:0] r7_dqm_reg, r7_dqp_reg;
    logic [DR_BITS-1:0] r7_drm_reg, r7_drm_next, r7_drp_reg, r7_drp_next;

    always_comb begin
        r7_drm_next = DR_BITS'(r6_d_reg - D_BITS'(r6_dqm_reg) * D_BITS'(DIV_MOM));
        r7_drp_next = DR_BITS'(r6_d_reg - D_BITS'(r6_dqp_reg) * D_BITS'(DIV_PROD));
    end

    always_ff @(posedge aclk) begin
        if (ready[6]) begin
            r6_d_reg   <= r5_d_reg;
            r6_dqm_reg <= DQ_BITS'(div15(32'(r5_d_reg >> SH_MOM)));
            r6_dqp_reg <= DQ_BITS'(div15(32'(r5_d_reg >> SH_PROD)));
        end
        if (ready[7]) begin
            r7_dqm_reg <= r6_dqm_reg;
            r7_dqp_reg <= r6_dqp_reg;
            r7_drm_reg <= r7_drm_next;
            r7_drp_reg <= r7_drp_next;
        end
    end

    // Stages 6 to 10: one lane per tensor entry; the last lane stage is the output
    // register.
    logic [OUT_BITS-1:0] res [6];

    for (genvar g = 0; g < 6; g++) begin : g_lane
        tit_tensor_lane #(
            .COORD_BITS (COORD_BITS),
            .PRODUCT    (g >= 3)
        ) u_lane (
            .aclk   (aclk),
            .en     (ready[NSTAGE:6]),
            .s_val  (r5_s_reg[g]),
            .dq     ((g >= 3) ? r7_dqp_reg : r7_dqm_reg),
            .dr     ((g >= 3) ? r7_drp_reg : r7_drm_reg),
            .result (res[g])
        );
    end

    assign m_tdata = {{M_PAD_BITS{1'b0}}, res[5], res[4], res[3], res[2], res[1], res[0]};

`ifndef NO_ASSERTIONS
    logic [NSTAGE:1] stall_mask;
    assign stall_mask = valid_reg & ~ready[NSTAGE:1];

    // A stage that cannot hand its request on must still hold it next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (stall_mask != '0) |=> ((valid_reg & $past(stall_mask)) == $past(stall_mask)))
        else $error("stalled pipeline stage lost its request");

    // An accepted request always lands in the first stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[1])
        else $error("accepted request did not enter the pipeline");

    // The reciprocal divide must leave a remainder below its divisor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[7] |-> ((r7_drm_reg < DR_BITS'(DIV_MOM)) &&
                          (r7_drp_reg < DR_BITS'(DIV_PROD))))
        else $error("determinant remainder out of range");
`endif

endmodule

// ===== rtl/tit_tensor_lane.sv =====
// One tensor entry: scales a coordinate sum by the determinant, divides, saturates.
module tit_tensor_lane #(
    parameter int COORD_BITS = 10,
    parameter bit PRODUCT    = 1'b0
) (
    input  logic                                   aclk,
    input  logic [4:0]                             en,
    input  logic signed [2*COORD_BITS+3:0]         s_val,
    input  logic [3*COORD_BITS-3:0]                dq,
    input  logic [tit_pkg::DR_BITS-1:0]            dr,
    output logic [tit_pkg::OUT_BITS-1:0]           result
);
    import tit_pkg::*;

    localparam int CB       = COORD_BITS;
    localparam int SM_BITS  = 2 * CB + 3;
    localparam int SQ_BITS  = 2 * CB - 2;
    localparam int DQ_BITS  = 3 * CB - 2;
    localparam int D_BITS   = 3 * CB + 3;
    localparam int P1_BITS  = DQ_BITS + SQ_BITS;
    localparam int P2_BITS  = DQ_BITS + DR_BITS + 1;
    localparam int P3_BITS  = 2 * DR_BITS;
    localparam int Q3_BITS  = P3_BITS - 6;
    localparam int ACC_BITS = D_BITS + SM_BITS;
    localparam int K        = PRODUCT ? DIV_PROD : DIV_MOM;
    localparam int SH       = PRODUCT ? SH_PROD : SH_MOM;

    // Split the sum as S = K * sq + sr, with the magnitude and sign kept apart.
    logic [SM_BITS-1:0]  a_mag_reg, a_mag_next;
    logic [SQ_BITS-1:0]  a_sq_reg, a_sq_next;
    logic                a_neg_reg, a_neg_next;
    logic [SQ_BITS-1:0]  b_sq_reg;
    logic [DR_BITS-1:0]  b_sr_reg, b_sr_next;
    logic                b_neg_reg;
    logic [P1_BITS-1:0]  c_p1_reg, c_p1_next;
    logic [P2_BITS-1:0]  c_p2_reg, c_p2_next;
    logic [P3_BITS-1:0]  c_p3_reg, c_p3_next;
    logic                c_neg_reg;
    logic [ACC_BITS-1:0] d_acc_reg, d_acc_next;
    logic [Q3_BITS-1:0]  d_p3q_reg, d_p3q_next;
    logic                d_neg_reg;
    logic [OUT_BITS-1:0] e_res_reg, e_res_next;
    logic [63:0]         quot;

    always_comb begin
        a_neg_next = (s_val < 0);
        a_mag_next = SM_BITS'(a_neg_next ? -s_val : s_val);
        a_sq_next  = SQ_BITS'(div15(32'(a_mag_next >> SH)));
    end

    assign b_sr_next = DR_BITS'(a_mag_reg - SM_BITS'(a_sq_reg) * SM_BITS'(K));

    // With D = K * dq + dr, floor(D * S / K) = K*dq*sq + dq*sr + dr*sq + floor(dr*sr / K).
    always_comb begin
        c_p1_next = P1_BITS'(dq) * P1_BITS'(b_sq_reg);
        c_p2_next = P2_BITS'(dq) * P2_BITS'(b_sr_reg) + P2_BITS'(dr) * P2_BITS'(b_sq_reg);
        c_p3_next = P3_BITS'(dr) * P3_BITS'(b_sr_reg);
    end

    always_comb begin
        d_acc_next = ACC_BITS'(c_p1_reg) * ACC_BITS'(K) + ACC_BITS'(c_p2_reg);
        d_p3q_next = Q3_BITS'(div15(32'(c_p3_reg >> SH)));
    end

    always_comb begin
        quot = 64'(d_acc_reg + ACC_BITS'(d_p3q_reg));
        if (PRODUCT) begin
            // The quotient is truncated toward zero and then negated.
            if (d_neg_reg) begin
                e_res_next = (quot > PROD_MAX) ? OUT_BITS'(PROD_MAX) : OUT_BITS'(quot);
            end else begin
                e_res_next = (quot > PROD_MIN_MAG) ? OUT_BITS'(PROD_MIN_MAG)
                                                   : OUT_BITS'(64'd0 - quot);
            end
        end else begin
            e_res_next = (quot > MOM_MAX) ? OUT_BITS'(MOM_MAX) : OUT_BITS'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a_mag_reg <= a_mag_next;
            a_sq_reg  <= a_sq_next;
            a_neg_reg <= a_neg_next;
        end
        if (en[1]) begin
            b_sq_reg  <= a_sq_reg;
            b_sr_reg  <= b_sr_next;
            b_neg_reg <= a_neg_reg;
        end
        if (en[2]) begin
            c_p1_reg  <= c_p1_next;
            c_p2_reg  <= c_p2_next;
            c_p3_reg  <= c_p3_next;
            c_neg_reg <= b_neg_reg;
        end
        if (en[3]) begin
            d_acc_reg <= d_acc_next;
            d_p3q_reg <= d_p3q_next;
            d_neg_reg <= c_neg_reg;
        end
        if (en[4]) begin
            e_res_reg <= e_res_next;
        end
    end

    assign result = e_res_reg;

endmodule
